@@ rtl/core/imh_pkg.sv @@
package imh_pkg;

	localparam int CAP   = 64;
	localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int OCC_W = $clog2(CAP + 1);
	localparam int CW    = IDX_W + 2;
	localparam int KEY_W = 64;
	localparam int POS_W = 6;
	localparam int ENT_W = 2 * KEY_W;

	localparam logic [2:0] M_ADD     = 3'd0;
	localparam logic [2:0] M_SET     = 3'd1;
	localparam logic [2:0] M_DEL     = 3'd2;
	localparam logic [2:0] M_MIN     = 3'd3;
	localparam logic [2:0] M_MAX     = 3'd4;
	localparam logic [2:0] M_EXTRACT = 3'd5;
	localparam logic [2:0] M_SEARCH  = 3'd6;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_DUP     = 3'd1,
		ST_MISSING = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_FULL    = 3'd4
	} st_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_FIND_RD,
		OP_FIND_CMP,
		OP_ADD_START,
		OP_SET_WR,
		OP_ROOT_RD,
		OP_ROOT_TAKE,
		OP_MAX_INIT,
		OP_MAX_RD,
		OP_MAX_CMP,
		OP_LAST_RD,
		OP_LAST_TAKE,
		OP_UP_RD,
		OP_UP_MOVE,
		OP_DN_RD_L,
		OP_DN_RD_R,
		OP_DN_MOVE,
		OP_HOLE_WR,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_START,
		S_FIND_RD,
		S_FIND_CMP,
		S_SET_WR,
		S_ROOT_RD,
		S_ROOT_TAKE,
		S_MAX_RD,
		S_MAX_CMP,
		S_LAST_RD,
		S_LAST_TAKE,
		S_UP_CHK,
		S_UP_CMP,
		S_DN_CHK,
		S_DN_RD_R,
		S_DN_CMP,
		S_HOLE_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t op;
		logic st_ld;
		st_t st;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [OCC_W-1:0] occ;
		logic scan_end;
		logic match;
		logic empty;
		logic full;
		logic hole_root;
		logic hole_past;
		logic down_dir;
		logic up_less;
		logic dn_leaf;
		logic dn_stop;
		logic out_busy;
	} stat_t;

endpackage

@@ rtl/core/imh_ctrl.sv @@
module imh_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  imh_pkg::stat_t stat,
	output imh_pkg::cmd_t cmd
);
	import imh_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		cmd.st_ld = 1'b0;
		cmd.st    = ST_OK;
		in_stall  = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_START;
				end
			end
			S_START: begin
				unique case (stat.mode)
					M_ADD, M_SET, M_DEL, M_SEARCH: state_d = S_FIND_RD;
					M_MIN, M_EXTRACT: begin
						if (stat.empty) begin
							cmd.st_ld = 1'b1;
							cmd.st    = ST_EMPTY;
							state_d   = S_DONE;
						end else begin
							state_d = S_ROOT_RD;
						end
					end
					M_MAX: begin
						if (stat.empty) begin
							cmd.st_ld = 1'b1;
							cmd.st    = ST_EMPTY;
							state_d   = S_DONE;
						end else begin
							cmd.op  = OP_MAX_INIT;
							state_d = S_MAX_RD;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_FIND_RD: begin
				if (stat.scan_end) begin
					if (stat.mode == M_ADD) begin
						if (stat.full) begin
							cmd.st_ld = 1'b1;
							cmd.st    = ST_FULL;
							state_d   = S_DONE;
						end else begin
							cmd.op  = OP_ADD_START;
							state_d = S_UP_CHK;
						end
					end else begin
						cmd.st_ld = 1'b1;
						cmd.st    = ST_MISSING;
						state_d   = S_DONE;
					end
				end else begin
					cmd.op  = OP_FIND_RD;
					state_d = S_FIND_CMP;
				end
			end
			S_FIND_CMP: begin
				cmd.op = OP_FIND_CMP;
				if (!stat.match) begin
					state_d = S_FIND_RD;
				end else begin
					unique case (stat.mode)
						M_ADD: begin
							cmd.st_ld = 1'b1;
							cmd.st    = ST_DUP;
							state_d   = S_DONE;
						end
						M_SET:   state_d = S_SET_WR;
						M_DEL:   state_d = S_LAST_RD;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SET_WR: begin
				cmd.op  = OP_SET_WR;
				state_d = S_DONE;
			end
			S_ROOT_RD: begin
				cmd.op  = OP_ROOT_RD;
				state_d = S_ROOT_TAKE;
			end
			S_ROOT_TAKE: begin
				cmd.op  = OP_ROOT_TAKE;
				state_d = (stat.mode == M_EXTRACT) ? S_LAST_RD : S_DONE;
			end
			S_MAX_RD: begin
				if (stat.scan_end) begin
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_MAX_RD;
					state_d = S_MAX_CMP;
				end
			end
			S_MAX_CMP: begin
				cmd.op  = OP_MAX_CMP;
				state_d = S_MAX_RD;
			end
			S_LAST_RD: begin
				cmd.op  = OP_LAST_RD;
				state_d = S_LAST_TAKE;
			end
			S_LAST_TAKE: begin
				cmd.op = OP_LAST_TAKE;
				priority if (stat.hole_past) begin
					state_d = S_DONE;
				end else if (stat.down_dir) begin
					state_d = S_DN_CHK;
				end else begin
					state_d = S_UP_CHK;
				end
			end
			S_UP_CHK: begin
				if (stat.hole_root) begin
					state_d = S_HOLE_WR;
				end else begin
					cmd.op  = OP_UP_RD;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_less) begin
					cmd.op  = OP_UP_MOVE;
					state_d = S_UP_CHK;
				end else begin
					state_d = S_HOLE_WR;
				end
			end
			S_DN_CHK: begin
				if (stat.dn_leaf) begin
					state_d = S_HOLE_WR;
				end else begin
					cmd.op  = OP_DN_RD_L;
					state_d = S_DN_RD_R;
				end
			end
			S_DN_RD_R: begin
				cmd.op  = OP_DN_RD_R;
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (stat.dn_stop) begin
					state_d = S_HOLE_WR;
				end else begin
					cmd.op  = OP_DN_MOVE;
					state_d = S_DN_CHK;
				end
			end
			S_HOLE_WR: begin
				cmd.op  = OP_HOLE_WR;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ rtl/core/imh_dp.sv @@
module imh_dp (
	input  logic clk,
	input  logic arst_n,
	input  imh_pkg::cmd_t cmd,
	output imh_pkg::stat_t stat,
	input  logic [2:0] mode,
	input  logic signed [imh_pkg::KEY_W-1:0] req_key,
	input  logic [imh_pkg::KEY_W-1:0] req_value,
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0] status,
	output logic signed [imh_pkg::KEY_W-1:0] res_key,
	output logic [imh_pkg::POS_W-1:0] res_position,
	output logic [imh_pkg::KEY_W-1:0] res_value
);
	import imh_pkg::*;

	logic [ENT_W-1:0] mem_q [CAP];
	logic [ENT_W-1:0] rd_q, ck_q, mv_q, pick_ent, wdata;
	logic [IDX_W-1:0] raddr, h_q, par, pick_idx;
	logic [OCC_W-1:0] occ_q, i_q;
	logic [CW-1:0] l_w, r_w, occ_w;
	logic [2:0] mode_q;
	logic [KEY_W-1:0] key_q, val_q, rkey_q, rval_q, rd_key, rd_val;
	logic [IDX_W-1:0] rpos_q;
	st_t st_q;
	logic out_valid_q, wen, has_r, pick_right, max_take;

	assign rd_key = rd_q[ENT_W-1:KEY_W];
	assign rd_val = rd_q[KEY_W-1:0];
	assign par    = (h_q - IDX_W'(1)) >> 1;
	assign l_w    = CW'({h_q, 1'b1});
	assign r_w    = l_w + CW'(1);
	assign occ_w  = CW'(occ_q);
	assign has_r  = r_w < occ_w;

	assign pick_right = has_r && ($signed(rd_key) < $signed(ck_q[ENT_W-1:KEY_W]));
	assign pick_ent   = pick_right ? rd_q : ck_q;
	assign pick_idx   = pick_right ? r_w[IDX_W-1:0] : l_w[IDX_W-1:0];
	assign max_take   = (i_q == (occ_q >> 1)) || ($signed(rd_key) > $signed(rkey_q));

	always_comb begin
		unique case (cmd.op)
			OP_ROOT_RD: raddr = '0;
			OP_LAST_RD: raddr = IDX_W'(occ_q - OCC_W'(1));
			OP_UP_RD:   raddr = par;
			OP_DN_RD_L: raddr = l_w[IDX_W-1:0];
			OP_DN_RD_R: raddr = r_w[IDX_W-1:0];
			default:    raddr = IDX_W'(i_q);
		endcase
	end

	always_comb begin
		wen   = 1'b1;
		wdata = mv_q;
		unique case (cmd.op)
			OP_SET_WR:  wdata = {key_q, val_q};
			OP_UP_MOVE: wdata = rd_q;
			OP_DN_MOVE: wdata = pick_ent;
			OP_HOLE_WR: wdata = mv_q;
			default:    wen = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[h_q] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_ADD_START) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (cmd.op == OP_LAST_RD) begin
				occ_q <= occ_q - OCC_W'(1);
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.st_ld) begin
			st_q <= cmd.st;
		end
		unique case (cmd.op)
			OP_LOAD: begin
				mode_q <= mode;
				key_q  <= req_key;
				val_q  <= req_value;
				i_q    <= '0;
				st_q   <= ST_OK;
				rkey_q <= req_key;
				rpos_q <= '0;
				rval_q <= '0;
			end
			OP_FIND_CMP: begin
				if (rd_key == key_q) begin
					h_q <= IDX_W'(i_q);
					if (mode_q == M_SEARCH) begin
						rpos_q <= IDX_W'(i_q);
						rval_q <= rd_val;
					end
				end else begin
					i_q <= i_q + OCC_W'(1);
				end
			end
			OP_ADD_START: begin
				h_q  <= IDX_W'(occ_q);
				mv_q <= {key_q, val_q};
			end
			OP_ROOT_TAKE: begin
				rkey_q <= rd_key;
				rval_q <= rd_val;
				h_q    <= '0;
			end
			OP_MAX_INIT: i_q <= occ_q >> 1;
			OP_MAX_CMP: begin
				if (max_take) begin
					rkey_q <= rd_key;
					rval_q <= rd_val;
					rpos_q <= IDX_W'(i_q);
				end
				i_q <= i_q + OCC_W'(1);
			end
			OP_LAST_TAKE: mv_q <= rd_q;
			OP_UP_MOVE:   h_q <= par;
			OP_DN_RD_R:   ck_q <= rd_q;
			OP_DN_MOVE:   h_q <= pick_idx;
			OP_OUT: begin
				status       <= st_q;
				res_key      <= rkey_q;
				res_position <= POS_W'(rpos_q);
				res_value    <= rval_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign stat.mode      = mode_q;
	assign stat.occ       = occ_q;
	assign stat.scan_end  = i_q >= occ_q;
	assign stat.match     = rd_key == key_q;
	assign stat.empty     = occ_q == '0;
	assign stat.full      = occ_q == OCC_W'(CAP);
	assign stat.hole_root = h_q == '0;
	assign stat.hole_past = OCC_W'(h_q) >= occ_q;
	assign stat.down_dir  = (h_q == '0) || ($signed(key_q) < $signed(rd_key));
	assign stat.up_less   = $signed(mv_q[ENT_W-1:KEY_W]) < $signed(rd_key);
	assign stat.dn_leaf   = l_w >= occ_w;
	assign stat.dn_stop   = $signed(mv_q[ENT_W-1:KEY_W]) < $signed(pick_ent[ENT_W-1:KEY_W]);
	assign stat.out_busy  = out_valid_q && out_stall;

endmodule

@@ rtl/core/indexed_min_heap.sv @@
// Indexed binary min-heap of up to 64 unique signed 64-bit keys, each with a
// 64-bit value word, kept in one slot memory. Every request gives
// exactly one result transaction with a status. Requests are handled one at a
// time: lookup by key walks the occupied slots one by one, a sift walks the
// heap level by level, and the max request walks the leaf slots. The memory
// has one read and one write port. A finished result waits in the output
// register while the next request is taken and worked on; that request's
// result is held back until the register has been handed over.
module indexed_min_heap (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [2:0] mode,
	input  logic signed [imh_pkg::KEY_W-1:0] req_key,
	input  logic [imh_pkg::KEY_W-1:0] req_value,
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0] status,
	output logic signed [imh_pkg::KEY_W-1:0] res_key,
	output logic [imh_pkg::POS_W-1:0] res_position,
	output logic [imh_pkg::KEY_W-1:0] res_value
);
	import imh_pkg::*;

	cmd_t cmd;
	stat_t stat;

	imh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	imh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.req_key      (req_key),
		.req_value    (req_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.res_key      (res_key),
		.res_position (res_position),
		.res_value    (res_value)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted transaction did not make the block busy");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.occ <= OCC_W'(CAP))
		else $error("occupancy above capacity");

	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.occ != $past(stat.occ)) |-> in_stall)
		else $error("occupancy changed while idle");

endmodule

@@ dv/indexed_min_heap_tb.sv @@
module indexed_min_heap_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import imh_pkg::*;

	localparam int HEAP_CAP = 64;
	localparam int RAND_ITEMS = 800;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [2:0] st;
		logic signed [63:0] k;
		logic [5:0] pos;
		logic [63:0] v;
	} heap_res_t;

	typedef struct {
		logic [2:0] md;
		logic signed [63:0] k;
		logic [63:0] v;
		logic chk;
		heap_res_t res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] mode;
	logic signed [63:0] req_key;
	logic [63:0] req_value;
	logic out_valid;
	logic out_stall;
	logic [2:0] status;
	logic signed [63:0] res_key;
	logic [5:0] res_position;
	logic [63:0] res_value;

	indexed_min_heap dut (.*);

	// heap shadow
	logic signed [63:0] hk[HEAP_CAP];
	logic [63:0] hv[HEAP_CAP];
	int heap_count;
	heap_res_t pending_results[$];
	logic signed [63:0] live_keys[$];

	int errors = 0;
	int sent = 0;
	int got = 0;
	int idle_cycles = 0;
	bit sender_done = 0;
	bit hold_off = 0;
	bit calm = 0;
	int n_full = 0, n_dup = 0, n_missing = 0, n_empty = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic int find_slot(logic signed [63:0] k);
		for (int i = 0; i < heap_count; i++)
			if (hk[i] == k) return i;
		return -1;
	endfunction

	function automatic void swap_entries(int a, int b);
		logic signed [63:0] tk;
		logic [63:0] tv;
		tk = hk[a]; tv = hv[a];
		hk[a] = hk[b]; hv[a] = hv[b];
		hk[b] = tk; hv[b] = tv;
	endfunction

	function automatic void sift_up(int i);
		int up;
		while (i > 0 && i < heap_count) begin
			up = (i - 1) / 2;
			if (!(hk[i] < hk[up])) break;
			swap_entries(i, up);
			i = up;
		end
	endfunction

	function automatic void sift_down(int i);
		int l, pick;
		while (2 * i + 1 < heap_count) begin
			l = 2 * i + 1;
			pick = l;
			if (l + 1 < heap_count && hk[l + 1] < hk[l]) pick = l + 1;
			if (hk[i] < hk[pick]) break;
			swap_entries(i, pick);
			i = pick;
		end
	endfunction

	function automatic void drop_slot(int p);
		logic signed [63:0] gone;
		gone = hk[p];
		heap_count--;
		hk[p] = hk[heap_count];
		hv[p] = hv[heap_count];
		if (p >= heap_count) return;
		if (p == 0 || gone < hk[p]) sift_down(p);
		else sift_up(p);
	endfunction

	function automatic heap_res_t heap_predict(logic [2:0] md, logic signed [63:0] k,
			logic [63:0] v);
		heap_res_t r;
		int p, best;
		r = '{st: ST_OK, k: k, pos: 6'd0, v: 64'd0};
		p = find_slot(k);
		case (md)
			M_ADD: begin
				if (p >= 0) r.st = ST_DUP;
				else if (heap_count >= HEAP_CAP) r.st = ST_FULL;
				else begin
					hk[heap_count] = k;
					hv[heap_count] = v;
					heap_count++;
					sift_up(heap_count - 1);
				end
			end
			M_SET: begin
				if (p >= 0) hv[p] = v;
				else r.st = ST_MISSING;
			end
			M_DEL: begin
				if (p >= 0) drop_slot(p);
				else r.st = ST_MISSING;
			end
			M_MIN, M_EXTRACT: begin
				if (heap_count == 0) r.st = ST_EMPTY;
				else begin
					r.k = hk[0];
					r.v = hv[0];
					if (md == M_EXTRACT) drop_slot(0);
				end
			end
			M_MAX: begin
				if (heap_count == 0) r.st = ST_EMPTY;
				else begin
					best = 0;
					for (int i = 0; i < heap_count; i++)
						if (2 * i + 1 >= heap_count && hk[best] < hk[i]) best = i;
					r.k = hk[best];
					r.pos = best[5:0];
					r.v = hv[best];
				end
			end
			M_SEARCH: begin
				if (p >= 0) begin
					r.pos = p[5:0];
					r.v = hv[p];
				end else r.st = ST_MISSING;
			end
			default: ;
		endcase
		case (r.st)
			ST_FULL: n_full++;
			ST_DUP: n_dup++;
			ST_MISSING: n_missing++;
			ST_EMPTY: n_empty++;
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic signed [63:0] fresh_key();
		logic signed [63:0] k;
		case ($urandom_range(0, 3))
			0: k = {$urandom, $urandom};
			1: k = $signed(64'($urandom_range(0, 40))) - 20;
			2: k = {1'b1, 63'($urandom_range(0, 15))};
			default: k = {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 15));
		endcase
		return k;
	endfunction

	function automatic logic signed [63:0] pick_key();
		if (live_keys.size() > 0 && $urandom_range(0, 3) != 0)
			return live_keys[$urandom_range(0, live_keys.size() - 1)];
		return fresh_key();
	endfunction

	localparam logic signed [63:0] KMIN = {1'b1, 63'd0};
	localparam logic signed [63:0] KMAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] VALL = '1;

	dir_row_t dir_rows[] = '{
		'{M_MIN, 64'sd5, 64'd0, 1'b1, '{ST_EMPTY, 64'sd5, 6'd0, 64'd0}},
		'{M_MAX, -64'sd1, 64'd0, 1'b1, '{ST_EMPTY, -64'sd1, 6'd0, 64'd0}},
		'{M_EXTRACT, KMIN, 64'd0, 1'b1, '{ST_EMPTY, KMIN, 6'd0, 64'd0}},
		'{M_SEARCH, KMAX, 64'd0, 1'b1, '{ST_MISSING, KMAX, 6'd0, 64'd0}},
		'{M_SET, 64'sd3, VALL, 1'b1, '{ST_MISSING, 64'sd3, 6'd0, 64'd0}},
		'{M_DEL, 64'sd3, 64'd0, 1'b1, '{ST_MISSING, 64'sd3, 6'd0, 64'd0}},
		'{M_ADD, KMAX, VALL, 1'b1, '{ST_OK, KMAX, 6'd0, 64'd0}},
		'{M_ADD, KMAX, 64'd1, 1'b1, '{ST_DUP, KMAX, 6'd0, 64'd0}},
		'{M_ADD, KMIN, 64'd0, 1'b1, '{ST_OK, KMIN, 6'd0, 64'd0}},
		'{M_MIN, 64'sd0, 64'd0, 1'b1, '{ST_OK, KMIN, 6'd0, 64'd0}},
		'{M_MAX, 64'sd0, 64'd0, 1'b1, '{ST_OK, KMAX, 6'd1, VALL}},
		'{M_ADD, 64'sd0, 64'h5555_aaaa_5555_aaaa, 1'b0, '0},
		'{M_ADD, -64'sd7, 64'haaaa_5555_aaaa_5555, 1'b0, '0},
		'{M_SET, 64'sd0, 64'h1234, 1'b0, '0},
		'{M_SEARCH, 64'sd0, 64'd0, 1'b0, '0},
		'{M_DEL, -64'sd7, 64'd0, 1'b0, '0},
		'{M_DEL, KMIN, 64'd0, 1'b0, '0},
		'{3'd7, 64'sd9, VALL, 1'b1, '{ST_OK, 64'sd9, 6'd0, 64'd0}},
		'{M_EXTRACT, 64'sd0, 64'd0, 1'b0, '0},
		'{M_EXTRACT, 64'sd0, 64'd0, 1'b1, '{ST_OK, KMAX, 6'd0, VALL}},
		'{M_EXTRACT, 64'sd0, 64'd0, 1'b1, '{ST_EMPTY, 64'sd0, 6'd0, 64'd0}}
	};

	task automatic send_request(logic [2:0] md, logic signed [63:0] k, logic [63:0] v,
			logic chk, heap_res_t res);
		heap_res_t p;
		while (!calm && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		req_key <= k;
		req_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		p = heap_predict(md, k, v);
		if (chk && p !== res) begin
			errors++;
			$display("%0t directed row mismatch: table %p predictor %p", $time, res, p);
		end
		pending_results = {pending_results, (chk ? res : p)};
		sent++;
		if (md == M_ADD && p.st == ST_OK) live_keys = {live_keys, k};
	endtask

	function automatic void forget_key(logic signed [63:0] k);
		foreach (live_keys[i])
			if (live_keys[i] == k) begin
				live_keys.delete(i);
				return;
			end
	endfunction

	task automatic random_request(int bias);
		logic [2:0] md;
		logic signed [63:0] k;
		int r;
		r = $urandom_range(0, 99);
		if (r < bias) md = M_ADD;
		else md = 3'($urandom_range(0, 7));
		k = (md == M_ADD && $urandom_range(0, 4) != 0) ? fresh_key() : pick_key();
		if (md == M_EXTRACT && heap_count > 0) forget_key(hk[0]);
		if (md == M_DEL && find_slot(k) >= 0) forget_key(k);
		send_request(md, k, {$urandom, $urandom}, 1'b0, '0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = '0;
		req_key = '0;
		req_value = '0;
		heap_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_request(dir_rows[i].md, dir_rows[i].k, dir_rows[i].v, dir_rows[i].chk,
				dir_rows[i].res);
		for (int i = 0; i < RAND_ITEMS; i++) begin
			calm = (i >= 300 && i < 400);
			hold_off = (i >= 100 && i < 110);
			if (i < 250) random_request(60);
			else if (i < 450) random_request(25);
			else random_request(40);
		end
		in_valid <= 1'b0;
		calm = 0;
		sender_done = 1;
	end

	// receiver
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (200) @(posedge clk);
				out_stall <= 1'b0;
				wait (!hold_off);
			end else
				out_stall <= (!calm && $urandom_range(0, 99) < 17);
		end
	end

	// result check
	always @(posedge clk) begin
		heap_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			got++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result st=%0d key=%0d", $time, status, res_key);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st) begin
					errors++;
					$display("%0t status exp %0d got %0d", $time, e.st, status);
				end
				if (res_key !== e.k) begin
					errors++;
					$display("%0t res_key exp %0d got %0d", $time, e.k, res_key);
				end
				if (res_position !== e.pos) begin
					errors++;
					$display("%0t res_position exp %0d got %0d", $time, e.pos, res_position);
				end
				if (res_value !== e.v) begin
					errors++;
					$display("%0t res_value exp %h got %h", $time, e.v, res_value);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		wait (sender_done);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d transactions in, %0d results out", sent, got);
		$display("errors seen: full %0d dup %0d missing %0d empty %0d", n_full, n_dup,
			n_missing, n_empty);
		if (errors == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/core/imh_pkg.sv
rtl/core/imh_ctrl.sv
rtl/core/imh_dp.sv
rtl/core/indexed_min_heap.sv
dv/indexed_min_heap_tb.sv
